// File: rtl/rpwm_pkg.sv
// rpwm_pkg: shared types and constants for the radiation pulse window meter.
// No dependencies.
`default_nettype none
package rpwm_pkg;

   localparam int unsigned CountWidth   = 16;
   localparam int unsigned SumWidth     = 25;
   localparam int unsigned RateWidth    = 24;
   localparam int unsigned DoseWidth    = 30;
   localparam int unsigned FactorWidth  = 24;
   localparam int unsigned ElapsedWidth = 9;
   localparam int unsigned DivWidth     = 9;
   localparam logic [ElapsedWidth-1:0] ElapsedMax = 9'd300;
   localparam logic [FactorWidth-1:0]  FactorReset = 24'd95630;

   typedef enum logic [1:0] {
      CMD_PULSE = 2'd0,
      CMD_TICK  = 2'd1,
      CMD_QUERY = 2'd2,
      CMD_NONE  = 2'd3
   } cmd_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_PULSE_RD,
      ST_PULSE_WR,
      ST_SUM,
      ST_SUM_LAST,
      ST_PROD_LO,
      ST_PROD_HI,
      ST_DIVIDE,
      ST_DONE
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic clear_step;
      logic pulse_write;
      logic tick;
      logic sum_start;
      logic sum_step;
      logic sum_last;
      logic prod_lo;
      logic prod_hi;
      logic div_start;
      logic div_step;
      logic rsp_load;
   } ctrl_type;

   // datapath -> controller
   typedef struct packed {
      logic clear_done;
      logic sum_done;
      logic div_done;
   } stat_type;

   function automatic logic [DivWidth-1:0] window_len(input logic [1:0] sel);
      logic [DivWidth-1:0] w;
      unique case (sel)
         2'd0: w = 9'd5;
         2'd1: w = 9'd15;
         2'd2: w = 9'd60;
         default: w = 9'd300;
      endcase
      return w;
   endfunction

endpackage
`default_nettype wire

// File: rtl/rpwm_ctrl.sv
// rpwm_ctrl: sequencer for the pulse window meter.
// Depends on rpwm_pkg.
`default_nettype none
module rpwm_ctrl
   import rpwm_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [1:0] req_cmd,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   input  wire stat_type   stat,
   output ctrl_type        ctrl
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   // the only path that waits on the output is the end of a query
   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      ctrl         = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            ctrl.clear_step = 1'b1;
            if (stat.clear_done) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (accept) begin
               unique case (req_cmd)
                  CMD_PULSE: state_in = ST_PULSE_RD;
                  CMD_TICK: ctrl.tick = 1'b1;
                  CMD_QUERY: begin
                     ctrl.sum_start = 1'b1;
                     state_in = ST_SUM;
                  end
                  default: ;
               endcase
            end
         end
         ST_PULSE_RD: state_in = ST_PULSE_WR;
         ST_PULSE_WR: begin
            ctrl.pulse_write = 1'b1;
            state_in = ST_IDLE;
         end
         ST_SUM: begin
            ctrl.sum_step = 1'b1;
            if (stat.sum_done) state_in = ST_SUM_LAST;
         end
         ST_SUM_LAST: begin
            ctrl.sum_last = 1'b1;
            state_in = ST_PROD_LO;
         end
         ST_PROD_LO: begin
            ctrl.prod_lo = 1'b1;
            state_in = ST_PROD_HI;
         end
         ST_PROD_HI: begin
            ctrl.prod_hi = 1'b1;
            ctrl.div_start = 1'b1;
            state_in = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            ctrl.div_step = 1'b1;
            if (stat.div_done) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               ctrl.rsp_load = 1'b1;
               rsp_valid_in  = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule
`default_nettype wire

// File: rtl/rpwm_datapath.sv
// rpwm_datapath: bucket ring memory, window summer, multiplier and
// restoring dividers. Depends on rpwm_pkg.
`default_nettype none
module rpwm_datapath
   import rpwm_pkg::*;
#(
   parameter int unsigned BUCKETS = 512
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire ctrl_type               ctrl,
   output stat_type                    stat,
   input  wire logic [1:0]             req_window_select,
   input  wire logic                   csr_write,
   input  wire logic [FactorWidth-1:0] csr_wdata,
   output logic [SumWidth-1:0]         rsp_window_count,
   output logic [RateWidth-1:0]        rsp_rate_x256,
   output logic [DoseWidth-1:0]        rsp_dose_x256
);

   localparam int unsigned IdxWidth = $clog2(BUCKETS);
   localparam logic [IdxWidth-1:0] LastIdx = IdxWidth'(BUCKETS - 1);
   // sum*factor first, then times 15360 by shift and subtract
   localparam int unsigned ProdWidth = SumWidth + FactorWidth;
   // dose numerator = sum*15360*factor, fits 63 bits
   localparam int unsigned NumWidth = 63;
   localparam int unsigned DivQ     = 40; // rate numerator bits (sum<<8 with slack)
   localparam int unsigned DenWidth = DivWidth + 24;

   logic [CountWidth-1:0] mem [BUCKETS];
   logic [CountWidth-1:0] rd_data_ff;
   logic [IdxWidth-1:0]   cur_ff, clr_idx_ff, rd_idx_ff;
   logic [ElapsedWidth-1:0] elapsed_ff;
   logic [FactorWidth-1:0]  factor_ff;
   logic [DivWidth-1:0]     left_ff, div_ff;
   logic [SumWidth-1:0]     sum_ff;
   logic [ProdWidth-1:0]    prod_ff;
   logic [5:0]              step_ff;

   // restoring dividers: rate (quotient of sum<<8 by div), dose (prod*15360 by div<<24)
   logic [DivQ-1:0]     rq_ff;
   logic [DivWidth-1:0] rr_ff;
   logic [NumWidth-1:0] dq_ff;
   logic [DenWidth-1:0] dr_ff;

   logic [IdxWidth-1:0] wr_idx;
   logic                wr_en;
   logic [CountWidth-1:0] wr_data;
   logic [IdxWidth-1:0]   rd_idx;

   always_comb begin
      wr_en   = 1'b0;
      wr_idx  = cur_ff;
      wr_data = '0;
      if (ctrl.clear_step) begin
         wr_en  = 1'b1;
         wr_idx = clr_idx_ff;
      end else if (ctrl.tick) begin
         wr_en  = 1'b1;
         wr_idx = (cur_ff == LastIdx) ? '0 : cur_ff + 1'b1;
      end else if (ctrl.pulse_write) begin
         wr_en   = 1'b1;
         wr_data = (rd_data_ff == '1) ? rd_data_ff : rd_data_ff + 1'b1;
      end
   end

   // read address: current bucket for a pulse, walk backwards for a sum
   always_comb begin
      rd_idx = cur_ff;
      if (ctrl.sum_start)
         rd_idx = (cur_ff == '0) ? LastIdx : cur_ff - 1'b1;
      else if (ctrl.sum_step)
         rd_idx = (rd_idx_ff == '0) ? LastIdx : rd_idx_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_idx] <= wr_data;
      rd_data_ff <= mem[rd_idx];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_ff     <= '0;
         clr_idx_ff <= '0;
         elapsed_ff <= '0;
         factor_ff  <= FactorReset;
      end else begin
         if (ctrl.clear_step) clr_idx_ff <= clr_idx_ff + 1'b1;
         if (ctrl.tick) begin
            cur_ff <= wr_idx;
            if (elapsed_ff != ElapsedMax) elapsed_ff <= elapsed_ff + 1'b1;
         end
         if (csr_write) factor_ff <= csr_wdata;
      end
   end

   // sum steps take buckets 1..W-1, the last step takes bucket W
   assign stat.clear_done = (clr_idx_ff == LastIdx);
   assign stat.sum_done   = (left_ff == 9'd2);
   assign stat.div_done   = (step_ff == '0);

   logic [DivWidth-1:0] w;
   assign w = window_len(req_window_select);

   logic [DivWidth:0]   rr_try;
   logic [DenWidth:0]   dr_try;
   logic [DenWidth-1:0] dden;
   assign dden   = {div_ff, 24'd0};
   assign rr_try = {rr_ff, rq_ff[DivQ-1]};
   assign dr_try = {dr_ff, dq_ff[NumWidth-1]};

   always_ff @(posedge clock) begin
      rd_idx_ff <= rd_idx;
      if (ctrl.sum_start) begin
         left_ff <= w;
         sum_ff  <= '0;
         div_ff  <= (elapsed_ff == '0 || elapsed_ff > w) ? w : elapsed_ff;
      end
      if (ctrl.sum_step) begin
         // data of the previous read lands here; first one is read on start
         sum_ff  <= sum_ff + SumWidth'(rd_data_ff);
         left_ff <= left_ff - 1'b1;
      end
      if (ctrl.sum_last) sum_ff <= sum_ff + SumWidth'(rd_data_ff);
      if (ctrl.prod_lo)
         prod_ff <= {{FactorWidth{1'b0}}, sum_ff} * {{SumWidth{1'b0}}, factor_ff};
      // 15360 = 2^14 - 2^10
      if (ctrl.prod_hi)
         dq_ff <= NumWidth'({prod_ff, 14'd0}) - NumWidth'({prod_ff, 10'd0});
      if (ctrl.div_start) begin
         rq_ff   <= DivQ'({sum_ff, 8'd0});
         rr_ff   <= '0;
         dr_ff   <= '0;
         step_ff <= 6'd62;
      end
      if (ctrl.div_step) begin
         if (step_ff < 6'd40) begin
            if (rr_try >= {1'b0, div_ff}) begin
               rr_ff <= DivWidth'(rr_try - {1'b0, div_ff});
               rq_ff <= {rq_ff[DivQ-2:0], 1'b1};
            end else begin
               rr_ff <= rr_try[DivWidth-1:0];
               rq_ff <= {rq_ff[DivQ-2:0], 1'b0};
            end
         end
         if (dr_try >= {1'b0, dden}) begin
            dr_ff <= DenWidth'(dr_try - {1'b0, dden});
            dq_ff <= {dq_ff[NumWidth-2:0], 1'b1};
         end else begin
            dr_ff <= dr_try[DenWidth-1:0];
            dq_ff <= {dq_ff[NumWidth-2:0], 1'b0};
         end
         // final step still shifts, quotient ready afterwards
         step_ff <= step_ff - 1'b1;
      end
      if (ctrl.rsp_load) begin
         rsp_window_count <= sum_ff;
         rsp_rate_x256    <= (rq_ff[DivQ-1:RateWidth] != '0) ? '1 : rq_ff[RateWidth-1:0];
         rsp_dose_x256    <= (dq_ff[NumWidth-1:DoseWidth] != '0) ? '1
                                                                 : dq_ff[DoseWidth-1:0];
      end
   end

endmodule
`default_nettype wire

// File: rtl/radiation_pulse_window_meter_core.sv
// radiation_pulse_window_meter_core: top level of the pulse window meter.
// A pulse reads and then writes back its bucket, a tick is done in the idle state, and a query
// reaches the result word by one bucket read per cycle (W = 5/15/60/300), then 63 steps of two dividers in step.
// Throughput: one word at a time.
// Reset (synchronous): a clearing pass over all BUCKETS entries zeroes the ring; no
// word is taken until it ends. Configuration writes are taken at all times outside reset.
// Depends on rpwm_pkg, rpwm_ctrl, rpwm_datapath.
`default_nettype none
module radiation_pulse_window_meter_core
   import rpwm_pkg::*;
#(
   parameter int unsigned BUCKETS = 512
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire logic [1:0]             req_cmd,
   input  wire logic [1:0]             req_window_select,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output logic [SumWidth-1:0]         rsp_window_count,
   output logic [RateWidth-1:0]        rsp_rate_x256,
   output logic [DoseWidth-1:0]        rsp_dose_x256,
   input  wire logic                   csr_write,
   input  wire logic [FactorWidth-1:0] csr_wdata
);

   ctrl_type ctrl;
   stat_type stat;

   // sequencer: handshakes and step commands
   rpwm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_cmd   (req_cmd),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .ctrl      (ctrl)
   );

   // ring memory, window sum, dose product, dividers, output register
   rpwm_datapath #(
      .BUCKETS (BUCKETS)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .ctrl              (ctrl),
      .stat              (stat),
      .req_window_select (req_window_select),
      .csr_write         (csr_write),
      .csr_wdata         (csr_wdata),
      .rsp_window_count  (rsp_window_count),
      .rsp_rate_x256     (rsp_rate_x256),
      .rsp_dose_x256     (rsp_dose_x256)
   );

endmodule
`default_nettype wire

// File: sim/radiation_pulse_window_meter_core_test.sv
// Testbench for radiation_pulse_window_meter_core: directed and random pulse, tick and query words
// checked against an in-bench model of the bucket ring, window sum, rate and dose.
// Depends on rpwm_pkg and the core RTL.
`timescale 1ns / 100ps
`default_nettype none

class window_scoreboard;
   logic [15:0] buckets [512];
   int unsigned now_pos;
   int unsigned elapsed;
   logic [23:0] factor;
   logic [24:0] count_q [$];
   logic [23:0] rate_q [$];
   logic [29:0] dose_q [$];
   int errors;

   function void clear_state();
      foreach (buckets[i]) buckets[i] = '0;
      now_pos = 0;
      elapsed = 0;
      factor = rpwm_pkg::FactorReset;
      errors = 0;
   endfunction

   function void set_factor(logic [23:0] value);
      factor = value;
   endfunction

   function int pending();
      return count_q.size();
   endfunction

   // Update the ring for one accepted word; a query queues its result.
   function void note_word(logic [1:0] cmd, logic [1:0] sel);
      int unsigned w, div;
      logic [63:0] sum, rate, dose;
      case (cmd)
         rpwm_pkg::CMD_PULSE: begin
            if (buckets[now_pos] != 16'hFFFF) buckets[now_pos]++;
         end
         rpwm_pkg::CMD_TICK: begin
            now_pos = (now_pos + 1) % 512;
            buckets[now_pos] = '0;
            if (elapsed < 300) elapsed++;
         end
         rpwm_pkg::CMD_QUERY: begin
            w = (sel == 2'd0) ? 5 : (sel == 2'd1) ? 15 : (sel == 2'd2) ? 60 : 300;
            sum = 0;
            for (int k = 1; k <= w; k++) sum += buckets[(now_pos + 512 - k) % 512];
            div = (elapsed == 0) ? w : ((elapsed < w) ? elapsed : w);
            rate = (sum * 256) / div;
            if (rate > 64'hFFFFFF) rate = 64'hFFFFFF;
            dose = (sum * 15360 * factor) / (64'(div) << 24);
            if (dose > 64'h3FFFFFFF) dose = 64'h3FFFFFFF;
            count_q.push_back(sum[24:0]);
            rate_q.push_back(rate[23:0]);
            dose_q.push_back(dose[29:0]);
         end
         default: ;
      endcase
   endfunction

   function void check_result(logic [24:0] cnt, logic [23:0] rate, logic [29:0] dose);
      logic [24:0] e_cnt;
      logic [23:0] e_rate;
      logic [29:0] e_dose;
      if (count_q.size() == 0) begin
         $display("%0t: unexpected result word count %0d", $time, cnt);
         errors++;
         return;
      end
      e_cnt = count_q.pop_front();
      e_rate = rate_q.pop_front();
      e_dose = dose_q.pop_front();
      if (cnt !== e_cnt) begin
         $display("%0t: window_count expected %0d actual %0d", $time, e_cnt, cnt);
         errors++;
      end
      if (rate !== e_rate) begin
         $display("%0t: rate_x256 expected %0d actual %0d", $time, e_rate, rate);
         errors++;
      end
      if (dose !== e_dose) begin
         $display("%0t: dose_x256 expected %0d actual %0d", $time, e_dose, dose);
         errors++;
      end
   endfunction
endclass

module radiation_pulse_window_meter_core_test;
   import rpwm_pkg::*;

   localparam int WatchLimit = 20000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [1:0] req_cmd = '0;
   logic [1:0] req_window_select = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [SumWidth-1:0] rsp_window_count;
   logic [RateWidth-1:0] rsp_rate_x256;
   logic [DoseWidth-1:0] rsp_dose_x256;
   logic csr_write = 1'b0;
   logic [FactorWidth-1:0] csr_wdata = '0;

   window_scoreboard meter_model;
   int send_idle_pct = 0;  // chance (percent) that the sender idles a cycle
   int stall_pct = 0;      // chance (percent) that the receiver stalls a cycle
   bit hold_off = 1'b0;    // long receiver hold-off in progress
   int quiet_cycles = 0;

   always #5 clock = ~clock;

   radiation_pulse_window_meter_core i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_cmd(req_cmd), .req_window_select(req_window_select),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_window_count(rsp_window_count), .rsp_rate_x256(rsp_rate_x256),
      .rsp_dose_x256(rsp_dose_x256),
      .csr_write(csr_write), .csr_wdata(csr_wdata)
   );

   // Result side: sample at the rising edge, pick the next stall at the falling one.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         meter_model.check_result(rsp_window_count, rsp_rate_x256, rsp_dose_x256);
   end

   always @(negedge clock) begin
      rsp_stall <= hold_off || ($urandom_range(99) < stall_pct);
   end

   // Watchdog: cycles with no word accepted on either side.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WatchLimit) begin
         $display("radiation_pulse_window_meter_core: mismatch");
         $finish;
      end
   end

   // Offer one word; valid stays high until accepted, the model notes it then.
   // Valid is left high on return so the next word can follow without a gap.
   task automatic send_word(input logic [1:0] cmd, input logic [1:0] sel);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_cmd <= cmd;
      req_window_select <= sel;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      meter_model.note_word(cmd, sel);
      @(negedge clock);
   endtask

   // Stop offering, wait until every queued result is in, then let a pulse settle.
   task automatic drain();
      req_valid <= 1'b0;
      while (meter_model.pending() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic write_factor(input logic [23:0] value);
      drain();
      csr_write <= 1'b1;
      csr_wdata <= value;
      @(negedge clock);
      csr_write <= 1'b0;
      meter_model.set_factor(value);
   endtask

   // Mostly pulses and ticks with a query now and then; cmd 3 as noise.
   task automatic random_words(input int n);
      int r;
      for (int i = 0; i < n; i++) begin
         r = $urandom_range(99);
         if (r < 50) send_word(CMD_PULSE, 2'($urandom));
         else if (r < 75) send_word(CMD_TICK, 2'($urandom));
         else if (r < 95) send_word(CMD_QUERY, 2'($urandom));
         else send_word(CMD_NONE, 2'($urandom));
      end
   endtask

   initial begin
      meter_model = new();
      meter_model.clear_state();
      repeat (6) @(negedge clock);
      reset <= 1'b0;

      // Directed: queries on an empty ring with elapsed at zero, every window.
      for (int s = 0; s < 4; s++) send_word(CMD_QUERY, 2'(s));
      send_word(CMD_NONE, 2'd3);
      send_word(CMD_PULSE, 2'd0);
      send_word(CMD_PULSE, 2'd1);
      send_word(CMD_TICK, 2'd0);
      send_word(CMD_QUERY, 2'd0);   // elapsed one, below the window
      send_word(CMD_PULSE, 2'd2);
      send_word(CMD_QUERY, 2'd3);
      send_word(CMD_TICK, 2'd3);
      for (int s = 0; s < 4; s++) send_word(CMD_QUERY, 2'(s));

      // Extreme factors.
      write_factor(24'hFFFFFF);
      send_word(CMD_QUERY, 2'd1);
      write_factor(24'd0);
      send_word(CMD_QUERY, 2'd1);
      write_factor(24'd1);
      send_word(CMD_TICK, 2'd0);
      send_word(CMD_QUERY, 2'd0);
      write_factor(24'hFFFFFF);
      send_word(CMD_QUERY, 2'd3);

      // Elapsed full and ring wrap: more than BUCKETS ticks with a few pulses.
      for (int i = 0; i < 520; i++) begin
         if (i % 13 == 0) send_word(CMD_PULSE, 2'd0);
         send_word(CMD_TICK, 2'($urandom));
      end
      for (int s = 0; s < 4; s++) send_word(CMD_QUERY, 2'(s));
      write_factor(FactorReset);

      // Random phases under different idle patterns.
      random_words(35);
      send_idle_pct = 70;
      random_words(35);
      write_factor(24'($urandom));
      send_idle_pct = 0;
      stall_pct = 70;
      random_words(35);
      send_idle_pct = 38;
      stall_pct = 38;
      random_words(35);
      send_idle_pct = 0;
      stall_pct = 0;

      // Long receiver hold-off while queries keep coming, so the input backs up.
      fork
         begin
            hold_off = 1'b1;
            repeat (3000) @(negedge clock);
            hold_off = 1'b0;
         end
         for (int i = 0; i < 12; i++) send_word(CMD_QUERY, 2'($urandom));
      join
      drain();  // sender pauses until every result is back
      write_factor(24'($urandom));
      random_words(35);

      drain();
      repeat (400) @(negedge clock);
      if (meter_model.errors == 0 && meter_model.pending() == 0)
         $display("radiation_pulse_window_meter_core: match");
      else
         $display("radiation_pulse_window_meter_core: mismatch");
      $finish;
   end
endmodule

`default_nettype wire

// File: filelist.f
rtl/rpwm_pkg.sv
rtl/rpwm_ctrl.sv
rtl/rpwm_datapath.sv
rtl/radiation_pulse_window_meter_core.sv
sim/radiation_pulse_window_meter_core_test.sv
